/* src/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the axis rotation unit
// Holds the CORDIC constants and the geometry word that rides the pipeline.
// ----------------------------------------------------------------------------
package rau_pkg;

  // CORDIC datapath: x, y in Q2.30 and z in 32-bit turn units, with headroom.
  localparam int CORDIC_ITERS = 28;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent of 2^-i in 32-bit turn units.
  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5
  };

  // Matrix entries are rounded to Q24 and held in this many bits.
  localparam int ELEM_FRAC = 24;
  localparam int EW        = 31;

  // Point and axis that travel alongside the trig pipeline.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } geo_t;

endpackage

/* src/rau_in_if.sv */
// ----------------------------------------------------------------------------
// rau_in_if: input channel of the axis rotation unit
// Valid/ready channel carrying a point, a unit axis and a binary angle.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic        [15:0] angle;

  modport source (output valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                  angle, input ready);
  modport sink (input valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                angle, output ready);
endinterface

/* src/rau_out_if.sv */
// ----------------------------------------------------------------------------
// rau_out_if: output channel of the axis rotation unit
// Valid/ready channel carrying the rotated point and a saturation flag.
// ----------------------------------------------------------------------------
interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic               saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

/* src/rau_cordic.sv */
// ----------------------------------------------------------------------------
// rau_cordic: pipelined CORDIC cosine and sine
// One register stage per iteration, plus an entry and a rounding stage.
// ----------------------------------------------------------------------------
module rau_cordic #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [15:0]                 angle_i,
  input  rau_pkg::geo_t               geo_i,
  output logic                        valid_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output rau_pkg::geo_t               geo_o
);
  import rau_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] HALF = CW'(1) << (SH - 1);
  localparam logic signed [CW-1:0] ONE  = CW'(1) << TRIG_FRAC_BITS;

  logic signed [CW-1:0] x_q [CORDIC_ITERS+1];
  logic signed [CW-1:0] y_q [CORDIC_ITERS+1];
  logic signed [CW-1:0] z_q [CORDIC_ITERS+1];
  logic                 flip_q [CORDIC_ITERS+1];
  logic                 vld_q [CORDIC_ITERS+1];
  geo_t                 geo_q [CORDIC_ITERS+1];

  // Entry stage: widen the angle to a full turn and fold it into half a turn.
  logic [23:0]           ang_ext;
  logic [ANGLE_BITS-1:0] ang_b;
  logic [31:0]           turn;
  logic                  flip_d;
  logic [31:0]           turn_f;

  always_comb begin
    ang_ext = 24'(angle_i);
    ang_b   = ang_ext[ANGLE_BITS-1:0];
    turn    = 32'(ang_b) << (32 - ANGLE_BITS);
    flip_d  = turn[31] ^ turn[30];
    turn_f  = {turn[31] ^ flip_d, turn[30:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= CW'(signed'(turn_f));
      flip_q[0] <= flip_d;
      geo_q[0]  <= geo_i;
    end
  end

  // Rotation stages, one micro-rotation each.
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = CW'(ATAN_TURNS[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        flip_q[i+1] <= flip_q[i];
        geo_q[i+1]  <= geo_q[i];
      end
    end
  end

  // Output stage: undo the fold, round to the trig format and clamp to +-1.
  logic signed [CW-1:0] xn, yn, xr, yr, cc, sc;

  always_comb begin
    xn = flip_q[CORDIC_ITERS] ? -x_q[CORDIC_ITERS] : x_q[CORDIC_ITERS];
    yn = flip_q[CORDIC_ITERS] ? -y_q[CORDIC_ITERS] : y_q[CORDIC_ITERS];
    xr = (xn + HALF) >>> SH;
    yr = (yn + HALF) >>> SH;
    cc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    sc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
  end

  logic                 vld_out_q;
  logic signed [TW-1:0] cos_q, sin_q;
  geo_t                 geo_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q     <= cc[TW-1:0];
      sin_q     <= sc[TW-1:0];
      geo_out_q <= geo_q[CORDIC_ITERS];
    end
  end

  assign valid_o = vld_out_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign geo_o   = geo_out_q;

endmodule

/* src/rau_matrix.sv */
// ----------------------------------------------------------------------------
// rau_matrix: axis-angle rotation matrix builder
// Four stages: axis and sine products, scaling by t, entry sums, Q24 rounding.
// ----------------------------------------------------------------------------
module rau_matrix #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  input  rau_pkg::geo_t                    geo_i,
  output logic                             valid_o,
  output logic signed [rau_pkg::EW-1:0]    elem_o [9],
  output rau_pkg::geo_t                    geo_o
);
  import rau_pkg::*;

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int TTW = TRIG_FRAC_BITS + 3;
  localparam int SW  = TW + 16;
  localparam int MW  = TRIG_FRAC_BITS + 35;
  localparam int RS  = TRIG_FRAC_BITS + 28 - ELEM_FRAC;
  localparam logic signed [TTW-1:0] ONE_T = TTW'(1) << TRIG_FRAC_BITS;
  localparam logic signed [MW-1:0]  HALF  = MW'(1) << (RS - 1);

  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Stage 1: products of axis components, s times axis, t = 1 - c.
  // Order of axis products: xx, yy, zz, xy, xz, yz.
  logic signed [31:0]  aa_q [6];
  logic signed [SW-1:0] sa_q [3];
  logic signed [TW-1:0]  c1_q;
  logic signed [TTW-1:0] t1_q;
  geo_t                  g1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q[0] <= geo_i.axis_x * geo_i.axis_x;
      aa_q[1] <= geo_i.axis_y * geo_i.axis_y;
      aa_q[2] <= geo_i.axis_z * geo_i.axis_z;
      aa_q[3] <= geo_i.axis_x * geo_i.axis_y;
      aa_q[4] <= geo_i.axis_x * geo_i.axis_z;
      aa_q[5] <= geo_i.axis_y * geo_i.axis_z;
      sa_q[0] <= sin_i * geo_i.axis_x;
      sa_q[1] <= sin_i * geo_i.axis_y;
      sa_q[2] <= sin_i * geo_i.axis_z;
      c1_q    <= cos_i;
      t1_q    <= ONE_T - TTW'(cos_i);
      g1_q    <= geo_i;
    end
  end

  // Stage 2: scale axis products by t and bring every term to a common point.
  logic signed [MW-1:0] taa_q [6];
  logic signed [MW-1:0] sas_q [3];
  logic signed [MW-1:0] cd_q;
  geo_t                 g2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        taa_q[k] <= t1_q * aa_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        sas_q[k] <= MW'(sa_q[k]) <<< 14;
      end
      cd_q <= MW'(c1_q) <<< 28;
      g2_q <= g1_q;
    end
  end

  // Stage 3: the nine entries, row by row.
  logic signed [MW-1:0] m_q [9];
  geo_t                 g3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= cd_q + taa_q[0];
      m_q[1] <= taa_q[3] - sas_q[2];
      m_q[2] <= taa_q[4] + sas_q[1];
      m_q[3] <= taa_q[3] + sas_q[2];
      m_q[4] <= cd_q + taa_q[1];
      m_q[5] <= taa_q[5] - sas_q[0];
      m_q[6] <= taa_q[4] - sas_q[1];
      m_q[7] <= taa_q[5] + sas_q[0];
      m_q[8] <= cd_q + taa_q[2];
      g3_q   <= g2_q;
    end
  end

  // Stage 4: round every entry to Q24.
  logic signed [MW-1:0] mr [9];
  logic signed [EW-1:0] e_q [9];
  geo_t                 g4_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mr[k] = (m_q[k] + HALF) >>> RS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        e_q[k] <= mr[k][EW-1:0];
      end
      g4_q <= g3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign elem_o  = e_q;
  assign geo_o   = g4_q;

endmodule

/* src/rau_apply.sv */
// ----------------------------------------------------------------------------
// rau_apply: matrix times point with rounding and saturation
// Three stages: nine products, row sums, round to Q16.16 and clamp.
// ----------------------------------------------------------------------------
module rau_apply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [rau_pkg::EW-1:0] elem_i [9],
  input  rau_pkg::geo_t                 geo_i,
  output logic                          valid_o,
  output logic signed [31:0]            rot_x_o,
  output logic signed [31:0]            rot_y_o,
  output logic signed [31:0]            rot_z_o,
  output logic                          sat_o
);
  import rau_pkg::*;

  localparam int PW = EW + 32;
  localparam int AW = 64;
  localparam logic signed [AW-1:0] HALF  = AW'(1) << (ELEM_FRAC - 1);
  localparam logic signed [AW-1:0] O_MAX = AW'(32'sh7FFFFFFF);
  localparam logic signed [AW-1:0] O_MIN = -(AW'(1) << 31);

  logic [2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Stage 1: every entry times its point component.
  logic signed [31:0]   pt [3];
  logic signed [PW-1:0] p_q [9];

  assign pt[0] = geo_i.point_x;
  assign pt[1] = geo_i.point_y;
  assign pt[2] = geo_i.point_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        p_q[k] <= elem_i[k] * pt[k % 3];
      end
    end
  end

  // Stage 2: row sums.
  logic signed [AW-1:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= AW'(p_q[3*r]) + AW'(p_q[3*r+1]) + AW'(p_q[3*r+2]);
      end
    end
  end

  // Stage 3: round to Q16.16 and clamp to the 32-bit range.
  logic signed [AW-1:0] rs [3];
  logic signed [31:0]   rc [3];
  logic [2:0]           hit;
  logic signed [31:0]   rot_q [3];
  logic                 sat_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rs[r] = (acc_q[r] + HALF) >>> ELEM_FRAC;
      if (rs[r] > O_MAX) begin
        rc[r]  = O_MAX[31:0];
        hit[r] = 1'b1;
      end else if (rs[r] < O_MIN) begin
        rc[r]  = O_MIN[31:0];
        hit[r] = 1'b1;
      end else begin
        rc[r]  = rs[r][31:0];
        hit[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rc;
      sat_q <= |hit;
    end
  end

  assign valid_o = vld_q[2];
  assign rot_x_o = rot_q[0];
  assign rot_y_o = rot_q[1];
  assign rot_z_o = rot_q[2];
  assign sat_o   = sat_q;

endmodule

/* src/rotate_about_unit_axis_unit.sv */
// ----------------------------------------------------------------------------
// rotate_about_unit_axis_unit: rotation of a point about a unit axis
// CORDIC trig, axis-angle matrix build and matrix-vector product, pipelined.
// ----------------------------------------------------------------------------
//   Channel  Dir  Word contents
//   in_i     in   point_x/y/z Q16.16, axis_x/y/z Q1.14, angle binary turn
//   out_o    out  rot_x/y/z Q16.16 saturated, saturated flag
//
// One word enters and one result leaves per cycle unless the output stalls.
// Words pass in order through the CORDIC (entry, iteration and rounding
// stages), the matrix build and the product and rounding.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled output freezes the whole pipeline in place, so no word is lost
// or repeated; in_i.ready follows the output stage.
// ----------------------------------------------------------------------------
module rotate_about_unit_axis_unit #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  logic                 en;
  logic                 tr_vld, mx_vld, ap_vld;
  logic signed [TW-1:0] cos_w, sin_w;
  geo_t                 geo_in, geo_tr, geo_mx;
  logic signed [EW-1:0] elem [9];

  // The pipeline advances whenever the output stage is empty or being taken.
  assign en         = !ap_vld || out_o.ready;
  assign in_i.ready = en;

  assign geo_in.point_x = in_i.point_x;
  assign geo_in.point_y = in_i.point_y;
  assign geo_in.point_z = in_i.point_z;
  assign geo_in.axis_x  = in_i.axis_x;
  assign geo_in.axis_y  = in_i.axis_y;
  assign geo_in.axis_z  = in_i.axis_z;

  rau_cordic #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .angle_i (in_i.angle),
    .geo_i   (geo_in),
    .valid_o (tr_vld),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .geo_o   (geo_tr)
  );

  rau_matrix #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_vld),
    .cos_i   (cos_w),
    .sin_i   (sin_w),
    .geo_i   (geo_tr),
    .valid_o (mx_vld),
    .elem_o  (elem),
    .geo_o   (geo_mx)
  );

  rau_apply u_apply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mx_vld),
    .elem_i  (elem),
    .geo_i   (geo_mx),
    .valid_o (ap_vld),
    .rot_x_o (out_o.rot_x),
    .rot_y_o (out_o.rot_y),
    .rot_z_o (out_o.rot_z),
    .sat_o   (out_o.saturated)
  );

  assign out_o.valid = ap_vld;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the axis rotation unit
// Drives points, axes and binary angles through the valid/ready channels,
// predicts each rotated point with a bit-exact CORDIC and Rodrigues model
// (or a hand result) and compares every output word field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_FRAC   = 14;
  localparam int NUM_RANDOM  = 1230;
  localparam int LATENCY     = 37;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ax, ay, az;
    logic        [15:0] ang;
  } vertex_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               sat;
  } rotated_t;

  // Directed row: a vertex, and optionally a result that is known by hand.
  typedef struct {
    vertex_t  v;
    bit       known;
    rotated_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rotate_about_unit_axis_unit #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  rotated_t pending_rot[$];
  int       errors;
  int       words_out;
  int       sat_seen;
  int       words_in;
  bit       in_done;

  // Floor shift and rounding with half added.
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Integer CORDIC giving cosine and sine in Q.TRIG_FRAC.
  function automatic void cordic_trig(logic [15:0] ang, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy, one;
    logic [31:0] turn;
    bit flip;
    x = rau_pkg::CORDIC_GAIN;
    y = 0;
    one = longint'(1) << TRIG_FRAC;
    turn = 32'(ang[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    flip = ((turn + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) begin
      turn = turn - 32'h8000_0000;
    end
    z = longint'($signed(turn));
    for (int i = 0; i < rau_pkg::CORDIC_ITERS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rau_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(rau_pkg::ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = round_shr(x, 30 - TRIG_FRAC);
    s = round_shr(y, 30 - TRIG_FRAC);
    if (c > one) c = one;
    if (c < -one) c = -one;
    if (s > one) s = one;
    if (s < -one) s = -one;
  endfunction

  // Rodrigues matrix times point, rounded to Q16.16 and saturated.
  function automatic rotated_t rotate_vertex(vertex_t v);
    longint p[3], a[3], m[3][3];
    longint c, s, t, cd, sa0, sa1, sa2, acc, r;
    logic signed [31:0] o[3];
    rotated_t res;
    bit sat;
    sat = 1'b0;
    p[0] = v.px; p[1] = v.py; p[2] = v.pz;
    a[0] = v.ax; a[1] = v.ay; a[2] = v.az;
    cordic_trig(v.ang, c, s);
    t = (longint'(1) << TRIG_FRAC) - c;
    cd = c << 28;
    sa0 = (s * a[0]) << 14;
    sa1 = (s * a[1]) << 14;
    sa2 = (s * a[2]) << 14;
    m[0][0] = cd + t * a[0] * a[0];
    m[0][1] = t * a[0] * a[1] - sa2;
    m[0][2] = t * a[0] * a[2] + sa1;
    m[1][0] = t * a[0] * a[1] + sa2;
    m[1][1] = cd + t * a[1] * a[1];
    m[1][2] = t * a[1] * a[2] - sa0;
    m[2][0] = t * a[0] * a[2] - sa1;
    m[2][1] = t * a[1] * a[2] + sa0;
    m[2][2] = cd + t * a[2] * a[2];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += round_shr(m[i][k], TRIG_FRAC + 28 - rau_pkg::ELEM_FRAC) * p[k];
      end
      r = round_shr(acc, rau_pkg::ELEM_FRAC);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647; sat = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648; sat = 1'b1;
      end
      o[i] = r[31:0];
    end
    res.rx = o[0]; res.ry = o[1]; res.rz = o[2]; res.sat = sat;
    return res;
  endfunction

  function automatic vertex_t make_vertex(int px, int py, int pz, int ax, int ay,
                                          int az, int ang);
    vertex_t v;
    v.px = px; v.py = py; v.pz = pz;
    v.ax = 16'(ax); v.ay = 16'(ay); v.az = 16'(az);
    v.ang = 16'(ang);
    return v;
  endfunction

  // Random vertex: mostly unit axes on a coordinate direction or a random
  // short axis, with points of mixed magnitude; some raw full-range noise.
  function automatic vertex_t random_vertex();
    vertex_t v;
    int sel;
    v.px = $urandom; v.py = $urandom; v.pz = $urandom;
    v.ax = 16'($urandom); v.ay = 16'($urandom); v.az = 16'($urandom);
    v.ang = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v.px = $signed(v.px) >>> $urandom_range(0, 16);
      v.py = $signed(v.py) >>> $urandom_range(0, 16);
      v.pz = $signed(v.pz) >>> $urandom_range(0, 16);
      v.ax = 0; v.ay = 0; v.az = 0;
      case ($urandom_range(0, 2))
        0: v.ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        1: v.ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        default: v.az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else if (sel < 8) begin
      v.px = $signed(v.px) >>> $urandom_range(0, 8);
      v.py = $signed(v.py) >>> $urandom_range(0, 8);
      v.pz = $signed(v.pz) >>> $urandom_range(0, 8);
      v.ax = $signed(v.ax) >>> 2;
      v.ay = $signed(v.ay) >>> 2;
      v.az = $signed(v.az) >>> 2;
    end
    return v;
  endfunction

  // Sender: bursts of words with random gaps between them.
  task automatic send_vertex(vertex_t v);
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= v.px;
    in_ch.point_y <= v.py;
    in_ch.point_z <= v.pz;
    in_ch.axis_x  <= v.ax;
    in_ch.axis_y  <= v.ay;
    in_ch.axis_z  <= v.az;
    in_ch.angle   <= v.ang;
    do @(posedge clk_i); while (!in_ch.ready);
    words_in++;
  endtask

  int burst_left;

  task automatic burst_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  row_t rows[$];

  initial begin
    row_t rw;
    vertex_t v;
    rotated_t zero_res;
    errors = 0; words_out = 0; sat_seen = 0; words_in = 0; in_done = 1'b0;
    burst_left = 0;
    zero_res = '{rx: 0, ry: 0, rz: 0, sat: 0};
    in_ch.valid <= 1'b0;
    in_ch.point_x <= '0; in_ch.point_y <= '0; in_ch.point_z <= '0;
    in_ch.axis_x <= '0; in_ch.axis_y <= '0; in_ch.axis_z <= '0;
    in_ch.angle <= '0;

    // Directed rows: zero point, quarter turns, extremes, odd axes.
    rw.known = 1'b1; rw.res = zero_res;
    rw.v = make_vertex(0, 0, 0, 16384, 0, 0, 16'h4000); rows.push_back(rw);
    rw.v = make_vertex(0, 0, 0, -32768, -32768, -32768, 16'hFFFF); rows.push_back(rw);
    rw.known = 1'b0;
    rw.v = make_vertex(65536, 0, 0, 0, 0, 16384, 16'h0000); rows.push_back(rw);
    rw.v = make_vertex(65536, 0, 0, 0, 0, 16384, 16'h4000); rows.push_back(rw);
    rw.v = make_vertex(65536, 0, 0, 0, 0, 16384, 16'h8000); rows.push_back(rw);
    rw.v = make_vertex(65536, 0, 0, 0, 0, 16384, 16'hC000); rows.push_back(rw);
    rw.v = make_vertex(0, 65536, 0, 16384, 0, 0, 16'h2000); rows.push_back(rw);
    rw.v = make_vertex(0, 0, 65536, 0, -16384, 0, 16'h3FFF); rows.push_back(rw);
    rw.v = make_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16384, 16384, 16384,
                       16'h1234); rows.push_back(rw);
    rw.v = make_vertex(32'h80000000, 32'h80000000, 32'h80000000, -16384, -16384,
                       -16384, 16'hBFFF); rows.push_back(rw);
    rw.v = make_vertex(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 16384, 16'h4000);
    rows.push_back(rw);
    rw.v = make_vertex(32'h7FFFFFFF, 32'h80000000, 1, 9459, 9459, 9459, 16'h8001);
    rows.push_back(rw);
    rw.v = make_vertex(123456, -654321, 777, 0, 0, 0, 16'h6000); rows.push_back(rw);
    rw.v = make_vertex(1, -1, 1, -32768, 0, 0, 16'h0001); rows.push_back(rw);
    rw.v = make_vertex(100000, 200000, -300000, 32767, 32767, -32768, 16'h5555);
    rows.push_back(rw);
    rw.v = make_vertex(-1, -1, -1, 16384, 0, 0, 16'hFFFF); rows.push_back(rw);
    rw.v = make_vertex(65536, 65536, 65536, 0, 11585, 11585, 16'h7FFF); rows.push_back(rw);
    rw.v = make_vertex(65536, 0, 0, 0, 0, 16384, 16'hC001); rows.push_back(rw);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      burst_gap();
      pending_rot.push_back(rows[i].known ? rows[i].res : rotate_vertex(rows[i].v));
      send_vertex(rows[i].v);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      v = random_vertex();
      burst_gap();
      pending_rot.push_back(rotate_vertex(v));
      send_vertex(v);
    end
    in_ch.valid <= 1'b0;
    in_done = 1'b1;
  end

  // Receiver: stalls on a pattern with long free-running stretches.
  logic [15:0] stall_lfsr = 16'hACE1;
  int          cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^
                     stall_lfsr[12] ^ stall_lfsr[10]};
      if (cyc[9:8] == 2'b01) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= (stall_lfsr[2:0] != 3'b000) && ($urandom_range(0, 5) != 0);
      end
    end
  end

  // Output check against the oldest expectation.
  always @(posedge clk_i) begin
    rotated_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (pending_rot.size() == 0) begin
        $error("unexpected output word rot_x=%0d", out_ch.rot_x);
        errors++;
      end else begin
        e = pending_rot.pop_front();
        if (out_ch.saturated) sat_seen++;
        if (out_ch.rot_x !== e.rx) begin
          $error("rot_x: expected %0d, got %0d", e.rx, out_ch.rot_x); errors++;
        end
        if (out_ch.rot_y !== e.ry) begin
          $error("rot_y: expected %0d, got %0d", e.ry, out_ch.rot_y); errors++;
        end
        if (out_ch.rot_z !== e.rz) begin
          $error("rot_z: expected %0d, got %0d", e.rz, out_ch.rot_z); errors++;
        end
        if (out_ch.saturated !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, out_ch.saturated);
          errors++;
        end
      end
    end
  end

  // Drain, then report.
  initial begin
    wait (in_done);
    while (pending_rot.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Rotated %0d vertices, %0d checked, %0d of them saturated.",
             words_in, words_out, sat_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout waiting for output words.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
